/* hw/rtl/pba_pkg.sv */
`timescale 1ns / 1ps

package pba_pkg;

   // slot map defaults
   localparam int MAX_SLOTS_DEF = 64;

   // field widths
   localparam int PORT_W   = 16;
   localparam int SEG_W    = 16;
   localparam int COUNT_W  = 7;
   localparam int IDX_W    = 8;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [PORT_W-1:0]  PORT_BASE_RST  = 16'd20000;
   localparam logic [SEG_W-1:0]   SEG_SIZE_RST   = 16'd500;
   localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 7'd64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PORT_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEG_SIZE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SLOT_COUNT = 2'd2;

   // request actions
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

   // control broadcast to every cell
   typedef struct packed {
      logic shift;  // move the search token one cell on
      logic kill;   // drop the search token
      logic grant;  // cell holding the token marks itself busy
   } cell_ctl_type;

endpackage

/* hw/rtl/pba_if.sv */
`timescale 1ns / 1ps

interface pba_req_if;
   import pba_pkg::*;
   logic             valid;
   logic             ready;
   logic             action;
   logic [IDX_W-1:0] slot_index;
   logic             iface_ready;

   modport source (output valid, action, slot_index, iface_ready, input ready);
   modport sink   (input valid, action, slot_index, iface_ready, output ready);
endinterface

interface pba_rsp_if;
   import pba_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   granted_slot;
   logic [PORT_W-1:0]   first_port;
   logic [PORT_W-1:0]   last_port;

   modport source (output valid, status, granted_slot, first_port, last_port,
                   input ready);
   modport sink   (input valid, status, granted_slot, first_port, last_port,
                   output ready);
endinterface

interface pba_csr_if;
   import pba_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/pba_cell.sv */
`timescale 1ns / 1ps

module pba_cell
   import pba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic         tok_left,
   input  logic         clear,
   output logic         tok_out,
   output logic         hit
);

   logic busy_ff, busy_in;
   logic tok_ff, tok_in;

   always_comb begin
      busy_in = busy_ff;
      if (ctl.grant && tok_ff) begin
         busy_in = 1'b1;
      end
      if (clear) begin
         busy_in = 1'b0;
      end
      tok_in = tok_ff;
      if (ctl.kill) begin
         tok_in = 1'b0;
      end else if (ctl.shift) begin
         tok_in = tok_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         tok_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         tok_ff  <= tok_in;
      end
   end

   assign tok_out = tok_ff;
   assign hit     = tok_ff & ~busy_ff;

endmodule

/* hw/rtl/port_block_allocator.sv */
`timescale 1ns / 1ps

// channel   role    handshake        payload
// req_ch    in      valid / ready    action, slot_index, iface_ready
// rsp_ch    out     valid / ready    status, granted_slot, first_port, last_port
// csr_ch    in      valid / ready    index, data (always ready)
//
// free and interface-not-ready items answer in the cycle after acceptance
// an allocate walks a token down the cell row, one slot per cycle, and
// grants the first free slot it reaches; a full miss ends past the last slot in use
// one item in flight at a time; the next is taken once the result register frees
// synchronous active-high reset clears all busy bits and loads register defaults
// a stalled rsp_ch holds the result and blocks new items and scan completion

module port_block_allocator
   import pba_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   pba_req_if.sink   req_ch,
   pba_rsp_if.source rsp_ch,
   pba_csr_if.sink   csr_ch
);

   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;

   // configuration registers
   logic [PORT_W-1:0]  port_base_ff;
   logic [SEG_W-1:0]   seg_size_ff;
   logic [COUNT_W-1:0] slot_count_ff;

   // control
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PORT_W-1:0] port_ff, port_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [PORT_W-1:0]   first_ff, first_in;
   logic [PORT_W-1:0]   last_ff, last_in;

   // cell row
   cell_ctl_type         ctl;
   logic [MAX_SLOTS-1:0] tok_vec;
   logic [MAX_SLOTS-1:0] hit_vec;
   logic [MAX_SLOTS-1:0] clr_vec;

   logic [CMP_W-1:0] n_eff;
   logic [CMP_W-1:0] cnt_wide;
   logic             out_free;
   logic             req_fire;
   logic             free_ok;
   logic             hit_any;
   logic             scan_end;
   logic             start;

   // slots in use, saturated at the row length
   assign n_eff = (CMP_W'(slot_count_ff) > CMP_W'(MAX_SLOTS)) ?
                  CMP_W'(MAX_SLOTS) : CMP_W'(slot_count_ff);
   assign cnt_wide = CMP_W'(cnt_ff);

   assign out_free = ~rsp_valid_ff | rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) & out_free;
   assign req_fire = req_ch.valid & req_ch.ready;
   assign free_ok  = req_fire & (req_ch.action == ACT_FREE) &
                     (CMP_W'(req_ch.slot_index) < n_eff);
   assign start    = req_fire & (req_ch.action == ACT_ALLOC) & req_ch.iface_ready;
   assign hit_any  = |hit_vec;
   // past the last slot in use: search has failed
   assign scan_end = (state_ff == S_SCAN) & (cnt_wide >= n_eff);

   assign csr_ch.ready = 1'b1;

   // free decode: at most one cell cleared per item
   always_comb begin
      for (int j = 0; j < MAX_SLOTS; j++) begin
         clr_vec[j] = free_ok && (CMP_W'(req_ch.slot_index) == CMP_W'(j));
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      port_in      = port_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      status_in    = status_ff;
      slot_in      = slot_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      ctl.shift    = 1'b0;
      ctl.kill     = 1'b0;
      ctl.grant    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               slot_in  = '0;
               first_in = '0;
               last_in  = '0;
               if (req_ch.action == ACT_FREE) begin
                  rsp_valid_in = 1'b1;
                  status_in    = free_ok ? ST_DONE : ST_BAD_INDEX;
               end else if (!req_ch.iface_ready) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_NOT_READY;
               end else begin
                  // inject the token into cell zero
                  ctl.shift = 1'b1;
                  cnt_in    = '0;
                  port_in   = port_base_ff;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan_end) begin
               if (out_free) begin
                  ctl.kill     = 1'b1;
                  rsp_valid_in = 1'b1;
                  status_in    = ST_NO_SLOT;
                  slot_in      = '0;
                  first_in     = '0;
                  last_in      = '0;
                  state_in     = S_IDLE;
               end
            end else if (hit_any) begin
               if (out_free) begin
                  ctl.grant    = 1'b1;
                  ctl.kill     = 1'b1;
                  rsp_valid_in = 1'b1;
                  status_in    = ST_DONE;
                  slot_in      = cnt_wide[SLOT_W-1:0];
                  first_in     = port_ff;
                  last_in      = port_ff + seg_size_ff;
                  state_in     = S_IDLE;
               end
            end else begin
               // slot busy: step on, next slot's first port mod 2^16
               ctl.shift = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
               port_in   = port_ff + seg_size_ff + PORT_W'(1);
            end
         end
         default: begin
            ctl.kill = 1'b1;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_base_ff  <= PORT_BASE_RST;
         seg_size_ff   <= SEG_SIZE_RST;
         slot_count_ff <= SLOT_COUNT_RST;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            REG_PORT_BASE:  port_base_ff  <= csr_ch.data[PORT_W-1:0];
            REG_SEG_SIZE:   seg_size_ff   <= csr_ch.data[SEG_W-1:0];
            REG_SLOT_COUNT: slot_count_ff <= csr_ch.data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      port_ff   <= port_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
   end

   // row of busy cells; the token enters at cell zero
   for (genvar j = 0; j < MAX_SLOTS; j++) begin : g_cell
      logic left;
      if (j == 0) begin : g_head
         assign left = start;
      end else begin : g_body
         assign left = tok_vec[j-1];
      end
      pba_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .tok_left (left),
         .clear    (clr_vec[j]),
         .tok_out  (tok_vec[j]),
         .hit      (hit_vec[j])
      );
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.granted_slot = slot_ff;
   assign rsp_ch.first_port   = first_ff;
   assign rsp_ch.last_port    = last_ff;

`ifndef ASSERT_OFF
   a_one_token : assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one search token in the cell row");

   a_idle_no_token : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (tok_vec == '0))
      else $error("search token left behind while idle");

   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (cnt_wide <= CMP_W'(MAX_SLOTS)))
      else $error("scan counter ran past the cell row");

   a_grant_single : assert property (@(posedge clock) disable iff (reset)
      ctl.grant |-> $onehot(hit_vec))
      else $error("grant without exactly one hitting cell");

   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != ST_DONE)) |->
      ((slot_ff == '0) && (first_ff == '0) && (last_ff == '0)))
      else $error("failed item carries nonzero fields");
`endif

endmodule

/* test/tb_port_block_allocator.sv */
`timescale 1ns / 1ps

module tb_port_block_allocator;
   import pba_pkg::*;

   localparam int MAX_SLOTS     = MAX_SLOTS_DEF;
   localparam int RESET_CYCLES  = 6;
   // a full miss scans every slot, plus a little slack
   localparam int DRAIN_CYCLES  = MAX_SLOTS + 8;
   // cycles with no handshake on any channel before the run is called hung
   localparam int QUIET_LIMIT   = 4000;
   localparam int LONG_STALL    = 300;
   localparam int RANDOM_PHASES = 14;
   localparam int PHASE_ITEMS   = 132;
   // register index with no register behind it
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic             action;
      logic [IDX_W-1:0] slot_index;
      logic             iface_ready;
   } slot_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   granted_slot;
      logic [PORT_W-1:0]   first_port;
      logic [PORT_W-1:0]   last_port;
   } port_grant_type;

   logic clock;
   logic reset;

   pba_req_if req_ch ();
   pba_rsp_if rsp_ch ();
   pba_csr_if csr_ch ();

   port_block_allocator #(
      .MAX_SLOTS (MAX_SLOTS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow copy of the block: registers and busy map
   logic [PORT_W-1:0]    cfg_base;
   logic [SEG_W-1:0]     cfg_seg;
   logic [COUNT_W-1:0]   cfg_count;
   logic [MAX_SLOTS-1:0] busy_map;

   slot_req_type   pending_reqs[$];     // items waiting to be offered
   port_grant_type expected_grants[$];  // predicted results, oldest first
   slot_req_type   offer;               // item currently on req_ch

   int send_idle_pct;
   int rsp_stall_pct;
   int stall_left;
   int quiet_cycles;
   int error_count;
   int grants_seen;

   always #1 clock = ~clock;

   // slots in use, saturated at the map size
   function automatic int unsigned live_slots();
      return (cfg_count > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_count);
   endfunction

   // mirror of one register write
   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_PORT_BASE:  cfg_base  = val[PORT_W-1:0];
         REG_SEG_SIZE:   cfg_seg   = val[SEG_W-1:0];
         REG_SLOT_COUNT: cfg_count = val[COUNT_W-1:0];
         default: ;
      endcase
   endfunction

   // next state of the busy map and the result of one accepted item
   function automatic port_grant_type predict_grant(input slot_req_type rq);
      port_grant_type g;
      int unsigned n;
      int          j;
      logic        found;
      logic [31:0] span;
      g     = '0;
      n     = live_slots();
      found = 1'b0;
      if (rq.action == ACT_FREE) begin
         // free never looks at iface_ready; freeing a free slot is fine
         if (rq.slot_index >= n) g.status = ST_BAD_INDEX;
         else busy_map[rq.slot_index] = 1'b0;
      end else if (!rq.iface_ready) begin
         // checked before the search, map untouched
         g.status = ST_NOT_READY;
      end else begin
         g.status = ST_NO_SLOT;
         for (j = 0; j < int'(n); j++) begin
            if (!found && !busy_map[j]) begin
               found          = 1'b1;
               busy_map[j]    = 1'b1;
               g.status       = ST_DONE;
               g.granted_slot = j[SLOT_W-1:0];
               // port math wraps at 16 bits
               span           = 32'(cfg_base) + 32'(j) * (32'(cfg_seg) + 32'd1);
               g.first_port   = span[PORT_W-1:0];
               g.last_port    = g.first_port + cfg_seg;
            end
         end
      end
      return g;
   endfunction

   // random item, mostly meaningful for the current slot count
   function automatic slot_req_type random_req(input int unsigned n);
      slot_req_type rq;
      int           pick;
      pick           = $urandom_range(99);
      rq.slot_index  = IDX_W'($urandom_range(255));
      rq.iface_ready = 1'b1;
      if (pick < 55) begin
         rq.action = ACT_ALLOC;
      end else if (pick < 63) begin
         rq.action      = ACT_ALLOC;
         rq.iface_ready = 1'b0;
      end else if (pick < 93) begin
         // free inside the live range
         rq.action      = ACT_FREE;
         rq.iface_ready = 1'($urandom_range(1));
         if (n > 0) rq.slot_index = IDX_W'($urandom_range(n - 1));
      end else begin
         // free anywhere in the index field
         rq.action      = ACT_FREE;
         rq.iface_ready = 1'($urandom_range(1));
      end
      return rq;
   endfunction

   task automatic report(input string what);
      error_count++;
      $display("mismatch: %s", what);
   endtask

   task automatic queue_req(input logic act, input logic [IDX_W-1:0] idx,
                            input logic rdy);
      slot_req_type rq;
      rq.action      = act;
      rq.slot_index  = idx;
      rq.iface_ready = rdy;
      pending_reqs.push_back(rq);
   endtask

   // register write on csr_ch, mirrored at the accepting edge
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      apply_reg(idx, val);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // sampled at the falling edge so driver and monitor updates have settled
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_ch.valid || expected_grants.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // driver: offers pending items, predicts each one at its accepting edge
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.action      <= ACT_ALLOC;
         req_ch.slot_index  <= '0;
         req_ch.iface_ready <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_grants.push_back(predict_grant(offer));
         // offer the next item once the current one is gone
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offer = pending_reqs.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.action      <= offer.action;
               req_ch.slot_index  <= offer.slot_index;
               req_ch.iface_ready <= offer.iface_ready;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long hold-off of the receiver, counted down here
   always @(posedge clock) begin
      if (stall_left > 0) stall_left <= stall_left - 1;
   end

   // monitor: random back-pressure and field-by-field compare
   always @(posedge clock) begin
      port_grant_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            grants_seen++;
            if (expected_grants.size() == 0) begin
               report($sformatf("result %0d arrived with no item pending", grants_seen));
            end else begin
               want = expected_grants.pop_front();
               if (rsp_ch.status !== want.status)
                  report($sformatf("result %0d status got %0d want %0d",
                                   grants_seen, rsp_ch.status, want.status));
               if (rsp_ch.granted_slot !== want.granted_slot)
                  report($sformatf("result %0d granted_slot got %0d want %0d",
                                   grants_seen, rsp_ch.granted_slot, want.granted_slot));
               if (rsp_ch.first_port !== want.first_port)
                  report($sformatf("result %0d first_port got %0d want %0d",
                                   grants_seen, rsp_ch.first_port, want.first_port));
               if (rsp_ch.last_port !== want.last_port)
                  report($sformatf("result %0d last_port got %0d want %0d",
                                   grants_seen, rsp_ch.last_port, want.last_port));
            end
         end
         rsp_ch.ready <= (stall_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // watchdog: any handshake on any channel counts as progress
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                   (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int          p;
      int          k;
      int unsigned n;
      logic [COUNT_W-1:0]    cnt;
      logic [CSR_DATA_W-1:0] base;
      logic [CSR_DATA_W-1:0] seg;

      // every input known from time zero
      clock              = 1'b0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.action      = ACT_ALLOC;
      req_ch.slot_index  = '0;
      req_ch.iface_ready = 1'b0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = REG_PORT_BASE;
      csr_ch.data        = '0;
      cfg_base           = PORT_BASE_RST;
      cfg_seg            = SEG_SIZE_RST;
      cfg_count          = SLOT_COUNT_RST;
      busy_map           = '0;
      send_idle_pct      = 0;
      rsp_stall_pct      = 0;
      stall_left         = 0;
      error_count        = 0;
      grants_seen        = 0;
      offer              = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset defaults: grant, not ready, free twice, range edges
      queue_req(ACT_ALLOC, 8'd255, 1'b1);
      queue_req(ACT_ALLOC, 8'd0,   1'b0);
      queue_req(ACT_ALLOC, 8'd0,   1'b1);
      queue_req(ACT_FREE,  8'd0,   1'b0);
      queue_req(ACT_FREE,  8'd0,   1'b1);
      queue_req(ACT_FREE,  8'd64,  1'b1);
      queue_req(ACT_FREE,  8'd255, 1'b0);
      queue_req(ACT_FREE,  8'd63,  1'b1);
      queue_req(ACT_ALLOC, 8'd170, 1'b1);
      wait_idle();

      // top of every register, count saturated, ports wrap
      write_reg(REG_PORT_BASE,  16'hFFFF);
      write_reg(REG_SEG_SIZE,   16'hFFFF);
      write_reg(REG_SLOT_COUNT, 16'h007F);
      write_reg(REG_SPARE,      16'hA5A5);
      queue_req(ACT_ALLOC, 8'd85, 1'b1);
      queue_req(ACT_FREE,  8'd64, 1'b1);
      queue_req(ACT_FREE,  8'd63, 1'b0);
      wait_idle();

      // shrink below busy slots: they stay busy and out of reach
      write_reg(REG_SLOT_COUNT, 16'd1);
      queue_req(ACT_FREE,  8'd2, 1'b1);
      queue_req(ACT_ALLOC, 8'd0, 1'b1);
      queue_req(ACT_FREE,  8'd0, 1'b1);
      queue_req(ACT_ALLOC, 8'd0, 1'b1);
      wait_idle();

      // zero slots and zero span
      write_reg(REG_SLOT_COUNT, 16'd0);
      write_reg(REG_PORT_BASE,  16'd0);
      write_reg(REG_SEG_SIZE,   16'd0);
      queue_req(ACT_ALLOC, 8'd0, 1'b1);
      queue_req(ACT_ALLOC, 8'd0, 1'b0);
      queue_req(ACT_FREE,  8'd0, 1'b1);
      wait_idle();

      // count restored, lowest free slot past the stranded ones
      write_reg(REG_SLOT_COUNT, 16'd64);
      queue_req(ACT_ALLOC, 8'd0, 1'b1);
      queue_req(ACT_ALLOC, 8'd0, 1'b1);
      wait_idle();

      // random phases, each with its own settings and idling mix
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 7)
            0:       cnt = 7'd64;
            1:       cnt = COUNT_W'($urandom_range(127, 65));
            2:       cnt = 7'd0;
            default: cnt = COUNT_W'($urandom_range(12, 1));
         endcase
         if (p == 3) base = 16'h0000;
         else if (p == 5) base = 16'hFFFF;
         else base = CSR_DATA_W'($urandom_range(16'hFFFF));
         if (p == 3) seg = 16'h0000;
         else if (p == 4) seg = 16'hFFFF;
         else if ($urandom_range(1)) seg = CSR_DATA_W'($urandom_range(16'hFFFF));
         else seg = CSR_DATA_W'($urandom_range(1000));
         write_reg(REG_PORT_BASE,  base);
         write_reg(REG_SEG_SIZE,   seg);
         write_reg(REG_SLOT_COUNT, 16'(cnt));

         case (p % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 48;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 48;
            end
            default: begin
               send_idle_pct = 6;
               rsp_stall_pct = 6;
            end
         endcase
         // receiver holds off while the sender keeps offering
         if (p == 2) stall_left = LONG_STALL;

         n = live_slots();
         for (k = 0; k < PHASE_ITEMS; k++) pending_reqs.push_back(random_req(n));
         // sender pauses here until every result is in
         wait_idle();
      end

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      wait_idle();
      if (error_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
